@@ rtl/core/ccl_pkg.sv @@
package ccl_pkg;

	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 19;
	localparam int CHUNK_W = 16;
	localparam int SLOT_W  = 4;
	localparam int OFF_W   = 16;
	localparam int COPY_W  = 17;

	// depth of the segment queue between splitter and tag store
	localparam int SEG_QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk;
		logic [OFF_W-1:0]   off;
		logic [COPY_W-1:0]  take;
		logic               past;
		logic               last;
	} seg_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_number;
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_valid;
		logic [CHUNK_W-1:0] evicted_chunk;
		logic [OFF_W-1:0]   offset_in_chunk;
		logic [COPY_W-1:0]  copy_bytes;
		logic               status;
		logic               last;
	} res_t;

endpackage

@@ rtl/core/chunk_cache_lru_splitter_top.sv @@
// Chunk cache splitter: a read request (byte_offset, byte_count) against a
// file of file_size bytes is cut into per-chunk segments, and each segment is
// looked up in a fully associative LRU tag store of CACHE_ENTRIES entries.
// One output beat per segment; last marks the final one of a request, and a
// request ends early at end of file or after MAX_SEGMENTS segments.
// CHUNK_BYTES must be a power of two. The splitter takes no new request until
// the last segment of the current one is queued, emits one segment per cycle
// while the queue is not full, and a small queue lets it run ahead of the tag
// store. The tag store handles a hit or a fill of a free entry at one segment
// per cycle while the output is not stalled; an eviction runs a registered
// min-stamp tree and takes no new segment until it has picked the victim.
// file_size may only be written while no request is in flight.
module chunk_cache_lru_splitter_top #(
	parameter int CHUNK_BYTES   = 65536,
	parameter int CACHE_ENTRIES = 16,
	parameter int MAX_SEGMENTS  = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [ccl_pkg::ADDR_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ccl_pkg::ADDR_W-1:0]   byte_offset,
	input  logic [ccl_pkg::LEN_W-1:0]    byte_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ccl_pkg::CHUNK_W-1:0]  chunk_number,
	output logic                         hit,
	output logic [ccl_pkg::SLOT_W-1:0]   slot,
	output logic                         evicted_valid,
	output logic [ccl_pkg::CHUNK_W-1:0]  evicted_chunk,
	output logic [ccl_pkg::OFF_W-1:0]    offset_in_chunk,
	output logic [ccl_pkg::COPY_W-1:0]   copy_bytes,
	output logic                         status,
	output logic                         last
);

	localparam int SEG_BITS = $bits(ccl_pkg::seg_t);

	logic [ccl_pkg::ADDR_W-1:0] file_size_q;
	logic                       f_valid;
	logic                       f_stall;
	ccl_pkg::seg_t              f_seg;
	logic                       q_empty;
	logic [SEG_BITS-1:0]        q_data;
	logic                       b_pop;
	ccl_pkg::seg_t              b_seg;
	ccl_pkg::res_t              b_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (cfg_wr_en) begin
			file_size_q <= cfg_wr_data;
		end
	end

	ccl_front #(
		.CHUNK_BYTES  (CHUNK_BYTES),
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.byte_offset (byte_offset),
		.byte_count  (byte_count),
		.file_size   (file_size_q),
		.seg_valid   (f_valid),
		.seg_stall   (f_stall),
		.seg         (f_seg)
	);

	ccl_fifo #(
		.WIDTH (SEG_BITS),
		.DEPTH (ccl_pkg::SEG_QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_data (f_seg),
		.full      (f_stall),
		.pop       (b_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	assign b_seg = ccl_pkg::seg_t'(q_data);

	ccl_back #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (!q_empty),
		.seg_pop   (b_pop),
		.seg       (b_seg),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res       (b_res)
	);

	assign chunk_number    = b_res.chunk_number;
	assign hit             = b_res.hit;
	assign slot            = b_res.slot;
	assign evicted_valid   = b_res.evicted_valid;
	assign evicted_chunk   = b_res.evicted_chunk;
	assign offset_in_chunk = b_res.offset_in_chunk;
	assign copy_bytes      = b_res.copy_bytes;
	assign status          = b_res.status;
	assign last            = b_res.last;

endmodule

@@ rtl/core/ccl_front.sv @@
module ccl_front #(
	parameter int CHUNK_BYTES  = 65536,
	parameter int MAX_SEGMENTS = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ccl_pkg::ADDR_W-1:0]  byte_offset,
	input  logic [ccl_pkg::LEN_W-1:0]   byte_count,
	input  logic [ccl_pkg::ADDR_W-1:0]  file_size,
	output logic                        seg_valid,
	input  logic                        seg_stall,
	output ccl_pkg::seg_t               seg
);

	localparam int CL    = $clog2(CHUNK_BYTES);
	localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
	localparam int PW    = ccl_pkg::ADDR_W + 1;
	localparam logic [PW-1:0] CB = PW'(CHUNK_BYTES);

	logic [PW-1:0]              pos_q;
	logic [ccl_pkg::LEN_W-1:0]  want_q;
	logic [ccl_pkg::LEN_W-1:0]  done_q;
	logic                       spans_q;
	logic                       busy_q;
	logic [SEG_W-1:0]           n_q;

	logic [PW-1:0]              off;
	logic [PW-1:0]              start;
	logic [PW-1:0]              fs;
	logic [PW-1:0]              diff;
	logic [PW-1:0]              avail;
	logic [PW-1:0]              rem;
	logic [PW-1:0]              room;
	logic [PW-1:0]              take0;
	logic [PW-1:0]              take;
	logic [PW-1:0]              chunk_all;
	logic [ccl_pkg::LEN_W-1:0]  done_nx;
	logic                       past;
	logic                       stop;
	logic                       spans_c;

	always_comb begin
		off       = PW'(pos_q[CL-1:0]);
		start     = pos_q - off;
		fs        = PW'(file_size);
		diff      = fs - start;
		// bytes of this chunk that lie inside the file
		avail     = (fs > start) ? ((diff < CB) ? diff : CB) : '0;
		rem       = PW'(want_q - done_q);
		room      = CB - off;
		take0     = (rem > room) ? room : rem;
		past      = off >= avail;
		take      = past ? '0 : (((off + take0) > avail) ? (avail - off) : take0);
		done_nx   = done_q + take[ccl_pkg::LEN_W-1:0];
		stop      = past || (done_nx >= want_q) || !spans_q ||
		            (n_q == SEG_W'(MAX_SEGMENTS - 1));
		chunk_all = pos_q >> CL;
		spans_c   = (PW'(byte_offset[CL-1:0]) + PW'(byte_count)) > CB;
	end

	assign in_stall  = busy_q;
	assign seg_valid = busy_q;

	always_comb begin
		seg.chunk = chunk_all[ccl_pkg::CHUNK_W-1:0];
		seg.off   = off[ccl_pkg::OFF_W-1:0];
		seg.take  = take[ccl_pkg::COPY_W-1:0];
		seg.past  = past;
		seg.last  = stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_q   <= '0;
			want_q  <= '0;
			done_q  <= '0;
			spans_q <= 1'b0;
			n_q     <= '0;
		end else if (in_valid && !busy_q) begin
			busy_q  <= 1'b1;
			pos_q   <= PW'(byte_offset);
			want_q  <= byte_count;
			done_q  <= '0;
			spans_q <= spans_c;
			n_q     <= '0;
		end else if (busy_q && !seg_stall) begin
			pos_q  <= pos_q + take;
			done_q <= done_nx;
			n_q    <= n_q + SEG_W'(1);
			if (stop) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/ccl_fifo.sv @@
module ccl_fifo #(
	parameter int WIDTH = 51,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/ccl_back.sv @@
module ccl_back #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          seg_valid,
	output logic          seg_pop,
	input  ccl_pkg::seg_t seg,
	output logic          res_valid,
	input  logic          res_stall,
	output ccl_pkg::res_t res
);

	localparam int N     = CACHE_ENTRIES;
	localparam int LVLS  = $clog2(N);
	localparam int P     = 1 << LVLS;
	localparam int IW    = (N > 1) ? $clog2(N) : 1;
	localparam int LV_W  = $clog2(LVLS + 2);
	localparam int SW    = 32;

	typedef enum logic {
		S_IDLE,
		S_REDUCE
	} state_t;

	state_t                      state_q;
	logic [N-1:0]                valid_q;
	logic [ccl_pkg::CHUNK_W-1:0] chunk_q [N];
	logic [SW-1:0]               stamp_q [N];
	logic [SW-1:0]               cnt_q;
	logic [LV_W-1:0]             lvl_q;
	ccl_pkg::seg_t               seg_q;
	ccl_pkg::res_t               res_q;
	logic                        res_valid_q;

	// min-stamp reduction tree, one level per cycle
	logic [SW-1:0]               cand_stamp_q [P];
	logic [IW-1:0]               cand_idx_q   [P];
	logic                        cand_vld_q   [P];

	logic                        out_free;
	logic                        start;
	logic                        hit_any;
	logic [IW-1:0]               hit_idx;
	logic                        free_any;
	logic [IW-1:0]               free_idx;
	logic [SW-1:0]               cnt_nx;
	logic                        load_cand;
	logic                        reduce_step;
	logic                        finish;
	logic                        res_load;
	logic [IW-1:0]               victim;
	logic                        wr_en;
	logic [IW-1:0]               wr_idx;
	logic [ccl_pkg::CHUNK_W-1:0] wr_tag;
	logic [SW-1:0]               wr_stamp;

	assign out_free    = !res_valid_q || !res_stall;
	assign start       = (state_q == S_IDLE) && seg_valid && out_free;
	assign seg_pop     = start;
	assign cnt_nx      = cnt_q + SW'(1);
	assign load_cand   = start && !hit_any && !free_any;
	assign reduce_step = (state_q == S_REDUCE) && (lvl_q != LV_W'(LVLS));
	assign finish      = (state_q == S_REDUCE) && (lvl_q == LV_W'(LVLS));
	assign res_load    = (start && (hit_any || free_any)) || finish;
	assign victim      = cand_idx_q[0];
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	// lowest matching entry and lowest free entry
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (valid_q[i] && chunk_q[i] == seg.chunk) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = '0;
		wr_tag   = seg.chunk;
		wr_stamp = cnt_nx;
		if (start) begin
			wr_en  = hit_any || free_any;
			wr_idx = hit_any ? hit_idx : free_idx;
		end else if (finish) begin
			wr_en    = 1'b1;
			wr_idx   = victim;
			wr_tag   = seg_q.chunk;
			wr_stamp = cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			chunk_q[wr_idx] <= wr_tag;
			stamp_q[wr_idx] <= wr_stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cand) begin
			seg_q <= seg;
			for (int i = 0; i < P; i++) begin
				cand_stamp_q[i] <= (i < N) ? stamp_q[i % N] : '0;
				cand_idx_q[i]   <= IW'(i);
				cand_vld_q[i]   <= i < N;
			end
		end else if (reduce_step) begin
			// right side wins only on a strictly smaller stamp
			for (int i = 0; i < P / 2; i++) begin
				if (cand_vld_q[2*i+1] && (!cand_vld_q[2*i] ||
				    cand_stamp_q[2*i+1] < cand_stamp_q[2*i])) begin
					cand_stamp_q[i] <= cand_stamp_q[2*i+1];
					cand_idx_q[i]   <= cand_idx_q[2*i+1];
					cand_vld_q[i]   <= 1'b1;
				end else begin
					cand_stamp_q[i] <= cand_stamp_q[2*i];
					cand_idx_q[i]   <= cand_idx_q[2*i];
					cand_vld_q[i]   <= cand_vld_q[2*i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			lvl_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q <= cnt_nx;
						if (hit_any || free_any) begin
							res_q.chunk_number    <= seg.chunk;
							res_q.hit             <= hit_any;
							res_q.slot            <= ccl_pkg::SLOT_W'(hit_any ? hit_idx : free_idx);
							res_q.evicted_valid   <= 1'b0;
							res_q.evicted_chunk   <= '0;
							res_q.offset_in_chunk <= seg.off;
							res_q.copy_bytes      <= seg.take;
							res_q.status          <= seg.past;
							res_q.last            <= seg.last;
						end else begin
							state_q <= S_REDUCE;
							lvl_q   <= '0;
						end
					end
				end
				S_REDUCE: begin
					if (reduce_step) begin
						lvl_q <= lvl_q + LV_W'(1);
					end else begin
						state_q               <= S_IDLE;
						res_q.chunk_number    <= seg_q.chunk;
						res_q.hit             <= 1'b0;
						res_q.slot            <= ccl_pkg::SLOT_W'(victim);
						res_q.evicted_valid   <= 1'b1;
						res_q.evicted_chunk   <= chunk_q[victim];
						res_q.offset_in_chunk <= seg_q.off;
						res_q.copy_bytes      <= seg_q.take;
						res_q.status          <= seg_q.past;
						res_q.last            <= seg_q.last;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/chunk_cache_lru_splitter_top_tb.sv @@
`timescale 1ns / 100ps

module chunk_cache_lru_splitter_top_tb;

	localparam int CB      = 65536;
	localparam int NENT    = 16;
	localparam int MAX_SEG = 5;
	localparam logic [31:0] DIR_FS = 20 * CB + 1234;

	typedef struct {
		logic [31:0] ofs;
		logic [18:0] cnt;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] byte_offset = '0;
	logic [18:0] byte_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] chunk_number;
	logic hit;
	logic [3:0] slot;
	logic evicted_valid;
	logic [15:0] evicted_chunk;
	logic [15:0] offset_in_chunk;
	logic [16:0] copy_bytes;
	logic status;
	logic last;

	// testbench copy of the register and the tag store
	logic [31:0] fsize = '0;
	bit ent_valid [NENT];
	logic [15:0] ent_tag [NENT];
	logic [31:0] ent_stamp [NENT];
	logic [31:0] use_cnt = '0;

	req_t req_pending[$];
	ccl_pkg::res_t seg_due[$];
	int err_cnt = 0;
	bit quiet = 1'b0;
	bit req_taken = 1'b0;
	int stall_left = 0;
	int gap_left = 0;

	chunk_cache_lru_splitter_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_offset(byte_offset),
		.byte_count(byte_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chunk_number(chunk_number),
		.hit(hit),
		.slot(slot),
		.evicted_valid(evicted_valid),
		.evicted_chunk(evicted_chunk),
		.offset_in_chunk(offset_in_chunk),
		.copy_bytes(copy_bytes),
		.status(status),
		.last(last)
	);

	always #10 clk = ~clk;

	task automatic queue_req(input req_t r);
		req_pending.insert(req_pending.size(), r);
	endtask

	task automatic lookup_tag(input logic [15:0] tag, inout ccl_pkg::res_t r);
		int pick;
		pick = -1;
		use_cnt = use_cnt + 1;
		r.hit = 1'b0;
		r.slot = '0;
		r.evicted_valid = 1'b0;
		r.evicted_chunk = '0;
		for (int i = 0; i < NENT; i++)
			if (pick < 0 && ent_valid[i] && ent_tag[i] == tag)
				pick = i;
		if (pick >= 0) begin
			ent_stamp[pick] = use_cnt;
			r.hit = 1'b1;
		end else begin
			for (int i = 0; i < NENT; i++)
				if (pick < 0 && !ent_valid[i])
					pick = i;
			if (pick < 0) begin
				// LRU victim, lowest index on equal stamps
				pick = 0;
				for (int i = 1; i < NENT; i++)
					if (ent_stamp[i] < ent_stamp[pick])
						pick = i;
				r.evicted_valid = 1'b1;
				r.evicted_chunk = ent_tag[pick];
			end
			ent_valid[pick] = 1'b1;
			ent_tag[pick] = tag;
			ent_stamp[pick] = use_cnt;
		end
		r.slot = pick[3:0];
	endtask

	task automatic split_request(input logic [31:0] first_byte, input logic [18:0] want_len);
		bit [63:0] pos, want, done, off, base, chunk, avail, take, fs;
		bit spans, past, stop;
		int n;
		ccl_pkg::res_t r;
		pos = first_byte;
		want = want_len;
		fs = fsize;
		done = 0;
		n = 0;
		spans = (pos % CB) + want > CB;
		do begin
			off = pos % CB;
			base = pos - off;
			chunk = pos / CB;
			avail = 0;
			if (fs > base)
				avail = (fs - base < CB) ? fs - base : CB;
			take = want - done;
			if (take > CB - off)
				take = CB - off;
			r = '0;
			lookup_tag(chunk[15:0], r);
			past = off >= avail;
			if (past)
				take = 0;
			else if (off + take > avail)
				take = avail - off;
			done += take;
			pos += take;
			stop = past || done >= want || !spans || n + 1 >= MAX_SEG;
			r.chunk_number = chunk[15:0];
			r.offset_in_chunk = off[15:0];
			r.copy_bytes = take[16:0];
			r.status = past;
			r.last = stop;
			seg_due.insert(seg_due.size(), r);
			n++;
		end while (!stop);
	endtask

	function automatic void chk_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	function automatic req_t make_req(input logic [31:0] fs, input int base_chunk);
		req_t r;
		longint p;
		bit [31:0] rnd;
		int sel, csel;
		sel = $urandom_range(0, 99);
		csel = $urandom_range(0, 9);
		if (csel < 4)
			r.cnt = $urandom_range(0, 4096);
		else if (csel < 7)
			r.cnt = $urandom_range(0, CB);
		else if (csel < 9)
			r.cnt = $urandom_range(0, 4 * CB);
		else
			r.cnt = $urandom_range(0, 1) ? 4 * CB : 4 * CB - 1;
		rnd = $urandom;
		if (sel < 60)
			p = longint'(base_chunk + $urandom_range(0, 23)) * CB + $urandom_range(0, CB - 1);
		else if (sel < 75)
			p = longint'(fs) + CB - $urandom_range(0, 3 * CB);
		else if (sel < 92)
			p = rnd;
		else case ($urandom_range(0, 2))
			0: p = 0;
			1: p = 32'hFFFF_FFFF;
			default: p = fs;
		endcase
		if (p < 0)
			p = 0;
		if (p > 32'hFFFF_FFFF)
			p = 32'hFFFF_FFFF;
		r.ofs = p[31:0];
		return r;
	endfunction

	task automatic set_file_size(input logic [31:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (req_pending.size() != 0 || in_valid || seg_due.size() != 0)
			@(posedge clk);
		// every expected beat has been checked; idle before the next phase
		repeat (40) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] fs, input int n, input int base_chunk);
		set_file_size(fs);
		for (int i = 0; i < n; i++)
			queue_req(make_req(fs, base_chunk));
		drain();
	endtask

	// sample side: register model, request acceptance, beat checks
	always @(posedge clk) begin
		ccl_pkg::res_t w;
		if (arst_n) begin
			if (cfg_wr_en)
				fsize = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (seg_due.size() == 0) begin
					$error("unexpected beat: chunk_number 0x%0h", chunk_number);
					err_cnt++;
				end else begin
					w = seg_due.pop_front();
					chk_field("chunk_number", w.chunk_number, chunk_number);
					chk_field("hit", w.hit, hit);
					chk_field("slot", w.slot, slot);
					chk_field("evicted_valid", w.evicted_valid, evicted_valid);
					chk_field("evicted_chunk", w.evicted_chunk, evicted_chunk);
					chk_field("offset_in_chunk", w.offset_in_chunk, offset_in_chunk);
					chk_field("copy_bytes", w.copy_bytes, copy_bytes);
					chk_field("status", w.status, status);
					chk_field("last", w.last, last);
				end
			end
			if (in_valid && !in_stall) begin
				split_request(byte_offset, byte_count);
				req_taken = 1'b1;
			end
		end
	end

	// drive side
	always @(negedge clk) begin
		req_t r;
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end

			if (!in_valid || req_taken) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (req_pending.size() != 0) begin
					r = req_pending.pop_front();
					byte_offset <= r.ofs;
					byte_count <= r.cnt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			req_taken = 1'b0;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_file_size(DIR_FS);
		queue_req('{32'd0, 19'd0});
		queue_req('{32'd0, 19'd1});
		queue_req('{CB - 1, 19'd1});
		queue_req('{CB - 1, 19'd2});
		queue_req('{32'd0, 19'd1});
		queue_req('{32'd0, 4 * CB});
		queue_req('{CB / 2, 4 * CB});
		queue_req('{CB - 1, 4 * CB - 1});
		// ending just short of end of file, then clipped across a boundary into end of file
		queue_req('{DIR_FS - 10, 19'd5});
		queue_req('{20 * CB - 100, 19'd3000});
		queue_req('{DIR_FS, 19'd10});
		queue_req('{DIR_FS + 3 * CB, 19'd0});
		queue_req('{32'hFFFF_FFFF, 4 * CB});
		queue_req('{32'hFFFF_FFFF, 19'd0});
		// fill past 16 entries to force LRU evictions
		for (int k = 1; k <= 4; k++)
			queue_req('{k * 4 * CB, 4 * CB});
		queue_req('{32'd0, 19'd1});
		queue_req('{5 * CB + 7, 19'd20});
		queue_req('{19 * CB, 19'd100});
		drain();

		run_phase(32'd0, 30, 0);
		run_phase(32'hFFFF_FFFF, 100, 65512);
		run_phase($urandom_range(1, 24 * CB), 100, 0);
		run_phase($urandom, 70, 0);
		quiet = 1'b1;
		run_phase(18 * CB + $urandom_range(0, CB - 1), 130, 0);

		if (err_cnt == 0)
			$display("chunk_cache_lru_splitter_top_tb: done, clean");
		else
			$display("chunk_cache_lru_splitter_top_tb: done, errors");
		$finish;
	end

	initial begin
		#8000000;
		$display("chunk_cache_lru_splitter_top_tb: done, errors");
		$finish;
	end

endmodule

@@ chunk_cache_lru_splitter_top.f @@
rtl/core/ccl_pkg.sv
rtl/core/ccl_front.sv
rtl/core/ccl_fifo.sv
rtl/core/ccl_back.sv
rtl/core/chunk_cache_lru_splitter_top.sv
tb/chunk_cache_lru_splitter_top_tb.sv
